// ===== hdl/bfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg: shared types and constants of the bus frame receiver
// Field widths, result codes, register indexes and result word layout.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int TICK_W    = 8;
    localparam int ADDR_W    = 12;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;

    // longest accepted message length in bytes
    localparam logic [BYTE_W-1:0] MAX_LEN = 8'd32;

    // default depth of the token queue between front and back
    localparam int FIFO_DEPTH = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 2'd3;

    // register reset values
    localparam logic [ADDR_W-1:0] RST_OWN_ADDR  = 12'd0;
    localparam logic [TICK_W-1:0] RST_BIT_THR   = 8'd8;
    localparam logic [TICK_W-1:0] RST_START_MIN = 8'd10;
    localparam logic [TICK_W-1:0] RST_START_MAX = 8'd254;

    // result kinds (m_tuser)
    localparam logic [1:0] EV_HEADER  = 2'd0;
    localparam logic [1:0] EV_DATA    = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;
    localparam logic [1:0] EV_ACK_REQ = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_START_LONG  = 3'd1;
    localparam logic [2:0] ERR_START_SHORT = 3'd2;
    localparam logic [2:0] ERR_PARITY      = 3'd3;
    localparam logic [2:0] ERR_LEN         = 3'd4;

    // field lengths in bits
    localparam logic [CNT_W-1:0] ADDR_BITS = 4'd12;
    localparam logic [CNT_W-1:0] CTRL_BITS = 4'd4;
    localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;

    // m_tdata layout, lowest bit up
    localparam int OFS_ERR    = 0;
    localparam int OFS_BCAST  = 3;
    localparam int OFS_MASTER = 4;
    localparam int OFS_SLAVE  = 16;
    localparam int OFS_MATCH  = 28;
    localparam int OFS_LEN    = 29;
    localparam int OFS_DATA   = 37;
    localparam int OFS_ACK    = 45;
    localparam int RES_BITS   = 46;
    localparam int M_DATA_W   = 48;

    typedef struct packed {
        logic [ADDR_W-1:0] own_address;
        logic [TICK_W-1:0] bit_threshold;
        logic [TICK_W-1:0] start_min;
        logic [TICK_W-1:0] start_max;
    } cfg_t;

    // classified pulse
    typedef struct packed {
        logic bit_one;
        logic too_long;
        logic too_short;
    } tok_t;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [2:0]        error_code;
        logic              is_broadcast;
        logic [ADDR_W-1:0] master_address;
        logic [ADDR_W-1:0] slave_address;
        logic              addressed_to_me;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] data_byte;
        logic              is_last;
        logic              drive_ack;
    } res_t;

endpackage

// ===== hdl/bfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_front: pulse classifier
// Accepts measured pulses and turns each into a token for the frame engine.
// ----------------------------------------------------------------------------
module bfr_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bfr_pkg::TICK_W-1:0]  s_tdata,    // [7:0] high_ticks
    input  bfr_pkg::cfg_t               cfg,
    input  logic                        q_full,
    output logic                        q_push,
    output bfr_pkg::tok_t               q_tok
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_tok.bit_one   = s_tdata < cfg.bit_threshold;
        q_tok.too_long  = s_tdata > cfg.start_max;
        q_tok.too_short = s_tdata < cfg.start_min;
    end

endmodule

// ===== hdl/bfr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_fifo: token queue
// Small register queue that decouples the classifier from the frame engine.
// ----------------------------------------------------------------------------
module bfr_fifo #(
    parameter int DEPTH = bfr_pkg::FIFO_DEPTH   // 2 or more
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bfr_pkg::tok_t push_tok,
    input  logic          pop,
    output bfr_pkg::tok_t pop_tok,
    output logic          full,
    output logic          empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bfr_pkg::tok_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_tok = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ===== hdl/bfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_back: frame engine
// Walks the frame fields one token per cycle while the queue holds a token and
// the output register is free, and loads results into the output register.
// ----------------------------------------------------------------------------
module bfr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  bfr_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  bfr_pkg::tok_t q_tok,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output bfr_pkg::res_t res
);

    typedef enum logic [15:0] {
        PH_IDLE  = 16'h0001,
        PH_BCAST = 16'h0002,
        PH_MAST  = 16'h0004,
        PH_MPAR  = 16'h0008,
        PH_SLAV  = 16'h0010,
        PH_SPAR  = 16'h0020,
        PH_ACK1  = 16'h0040,
        PH_CTRL  = 16'h0080,
        PH_CPAR  = 16'h0100,
        PH_ACK2  = 16'h0200,
        PH_LEN   = 16'h0400,
        PH_LPAR  = 16'h0800,
        PH_ACK3  = 16'h1000,
        PH_DATA  = 16'h2000,
        PH_DPAR  = 16'h4000,
        PH_DACK  = 16'h8000
    } phase_t;

    phase_t                            phase_reg,  phase_next;
    logic [bfr_pkg::CNT_W-1:0]         cnt_reg,    cnt_next;
    logic [bfr_pkg::ADDR_W-1:0]        shift_reg,  shift_next;
    logic                              par_reg,    par_next;
    logic                              bcast_reg,  bcast_next;
    logic [bfr_pkg::ADDR_W-1:0]        master_reg, master_next;
    logic [bfr_pkg::ADDR_W-1:0]        slave_reg,  slave_next;
    logic                              match_reg,  match_next;
    logic [bfr_pkg::BYTE_W-1:0]        len_reg,    len_next;
    logic [bfr_pkg::BYTE_W-1:0]        idx_reg,    idx_next;
    logic                              m_valid_reg;
    bfr_pkg::res_t                     res_reg;

    logic                              out_free;
    logic                              emit;
    bfr_pkg::res_t                     res_new;
    logic [bfr_pkg::CNT_W-1:0]         cnt_inc;
    logic [bfr_pkg::ADDR_W-1:0]        shift_in;
    logic                              par_in;
    logic                              par_ok;
    logic                              len_big;
    logic [bfr_pkg::BYTE_W-1:0]        idx_inc;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = !q_empty && out_free;
    assign m_tvalid = m_valid_reg;
    assign res      = res_reg;

    assign cnt_inc  = cnt_reg + 1'b1;
    assign shift_in = {shift_reg[bfr_pkg::ADDR_W-2:0], q_tok.bit_one};
    assign par_in   = par_reg ^ q_tok.bit_one;
    assign par_ok   = q_tok.bit_one == par_reg;
    assign len_big  = len_reg > bfr_pkg::MAX_LEN;
    assign idx_inc  = idx_reg + 1'b1;

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        par_next    = par_reg;
        bcast_next  = bcast_reg;
        master_next = master_reg;
        slave_next  = slave_reg;
        match_next  = match_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        emit        = 1'b0;

        res_new.event_res       = bfr_pkg::EV_ERROR;
        res_new.error_code      = bfr_pkg::ERR_NONE;
        res_new.is_broadcast    = bcast_reg;
        res_new.master_address  = master_reg;
        res_new.slave_address   = slave_reg;
        res_new.addressed_to_me = match_reg;
        res_new.length          = len_reg;
        res_new.data_byte       = '0;
        res_new.is_last         = 1'b0;
        res_new.drive_ack       = 1'b0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (q_tok.too_long || q_tok.too_short) begin
                    emit = 1'b1;
                    res_new.error_code      = q_tok.too_long ? bfr_pkg::ERR_START_LONG
                                                             : bfr_pkg::ERR_START_SHORT;
                    res_new.is_broadcast    = 1'b0;
                    res_new.master_address  = '0;
                    res_new.slave_address   = '0;
                    res_new.addressed_to_me = 1'b0;
                    res_new.length          = '0;
                end else begin
                    phase_next = PH_BCAST;
                end
            end
            PH_BCAST: begin
                bcast_next = q_tok.bit_one;
                phase_next = PH_MAST;
                cnt_next   = '0;
                shift_next = '0;
                par_next   = 1'b0;
            end
            PH_MAST, PH_SLAV, PH_CTRL, PH_LEN, PH_DATA: begin
                cnt_next   = cnt_inc;
                shift_next = shift_in;
                par_next   = par_in;
                if (phase_reg == PH_MAST && cnt_inc >= bfr_pkg::ADDR_BITS) begin
                    master_next = shift_in;
                    phase_next  = PH_MPAR;
                end
                if (phase_reg == PH_SLAV && cnt_inc >= bfr_pkg::ADDR_BITS) begin
                    slave_next = shift_in;
                    match_next = shift_in == cfg.own_address;
                    phase_next = PH_SPAR;
                end
                if (phase_reg == PH_CTRL && cnt_inc >= bfr_pkg::CTRL_BITS) begin
                    phase_next = PH_CPAR;
                end
                if (phase_reg == PH_LEN && cnt_inc >= bfr_pkg::BYTE_BITS) begin
                    len_next   = shift_in[bfr_pkg::BYTE_W-1:0];
                    phase_next = PH_LPAR;
                end
                if (phase_reg == PH_DATA && cnt_inc >= bfr_pkg::BYTE_BITS) begin
                    phase_next = PH_DPAR;
                end
            end
            PH_MPAR, PH_SPAR, PH_CPAR, PH_LPAR, PH_DPAR: begin
                if (!par_ok) begin
                    emit = 1'b1;
                    res_new.error_code = bfr_pkg::ERR_PARITY;
                    phase_next = PH_IDLE;
                end else if (phase_reg == PH_MPAR) begin
                    phase_next = PH_SLAV;
                    cnt_next   = '0;
                    shift_next = '0;
                    par_next   = 1'b0;
                end else if (phase_reg == PH_SPAR || phase_reg == PH_CPAR) begin
                    phase_next = (phase_reg == PH_SPAR) ? PH_ACK1 : PH_ACK2;
                    emit = match_reg;
                    res_new.event_res = bfr_pkg::EV_ACK_REQ;
                    res_new.drive_ack = 1'b1;
                end else if (phase_reg == PH_LPAR) begin
                    phase_next = PH_ACK3;
                    if (!len_big) begin
                        emit = 1'b1;
                        res_new.event_res = bfr_pkg::EV_HEADER;
                        res_new.is_last   = len_reg == '0;
                        res_new.drive_ack = match_reg;
                    end else begin
                        // oversized frame: still ack the header if it is ours
                        emit = match_reg;
                        res_new.event_res = bfr_pkg::EV_ACK_REQ;
                        res_new.drive_ack = 1'b1;
                    end
                end else begin
                    phase_next = PH_DACK;
                    emit = 1'b1;
                    res_new.event_res = bfr_pkg::EV_DATA;
                    res_new.data_byte = shift_reg[bfr_pkg::BYTE_W-1:0];
                    res_new.is_last   = idx_inc == len_reg;
                    res_new.drive_ack = match_reg;
                end
            end
            PH_ACK1, PH_ACK2: begin
                phase_next = (phase_reg == PH_ACK1) ? PH_CTRL : PH_LEN;
                cnt_next   = '0;
                shift_next = '0;
                par_next   = 1'b0;
            end
            PH_ACK3: begin
                if (len_big) begin
                    emit = 1'b1;
                    res_new.error_code = bfr_pkg::ERR_LEN;
                    phase_next = PH_IDLE;
                end else begin
                    idx_next = '0;
                    if (len_reg == '0) begin
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_DATA;
                        cnt_next   = '0;
                        shift_next = '0;
                        par_next   = 1'b0;
                    end
                end
            end
            PH_DACK: begin
                idx_next = idx_inc;
                if (idx_inc >= len_reg) begin
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_DATA;
                    cnt_next   = '0;
                    shift_next = '0;
                    par_next   = 1'b0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            shift_reg   <= '0;
            par_reg     <= 1'b0;
            bcast_reg   <= 1'b0;
            master_reg  <= '0;
            slave_reg   <= '0;
            match_reg   <= 1'b0;
            len_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                shift_reg  <= shift_next;
                par_reg    <= par_next;
                bcast_reg  <= bcast_next;
                master_reg <= master_next;
                slave_reg  <= slave_next;
                match_reg  <= match_next;
                len_reg    <= len_next;
                idx_reg    <= idx_next;
            end
            if (out_free) begin
                m_valid_reg <= q_pop && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            res_reg <= res_new;
        end
    end

endmodule

// ===== hdl/bus_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_frame_receiver_top: serial bus frame receiver
// Decodes measured bit-slot pulses into header, data byte, ack and error
// results.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one measured high time per bit slot (s_tdata = high_ticks).
//   m_* carries results: kind in m_tuser, last-byte mark in m_tlast and the
//   frame fields in m_tdata. cfg_* writes the four setup registers; write
//   them only while no frame is in flight.
// Throughput: one pulse per cycle while s_tready is high. The classifier
//   takes the pulse into a token queue at the transfer; the frame engine
//   retires one token a cycle while the output register is free.
// Path: a result reaches m_tvalid after its pulse has gone through the queue
//   and then the output register, later if tokens are already waiting.
// Stall: while m_tready is low the output register holds its result and the
//   engine stops; the queue then takes up to FIFO_DEPTH more pulses before
//   s_tready drops.
// Reset: aresetn low at a clock edge empties the queue, clears m_tvalid,
//   returns the engine to idle and reloads the register defaults.
// ----------------------------------------------------------------------------
module bus_frame_receiver_top #(
    parameter int FIFO_DEPTH = bfr_pkg::FIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfr_pkg::TICK_W-1:0]     s_tdata,   // [7:0] high_ticks
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] error_code, [3] is_broadcast, [15:4] master_address,
    // [27:16] slave_address, [28] addressed_to_me, [36:29] length,
    // [44:37] data_byte, [45] drive_ack, [47:46] zero
    output logic [bfr_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [1:0]                     m_tuser,   // [1:0] event_res
    output logic                           m_tlast,   // is_last
    input  logic                           cfg_wr_en,
    input  logic [bfr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [bfr_pkg::CFG_W-1:0]      cfg_wdata
);

    bfr_pkg::cfg_t cfg_reg;
    bfr_pkg::tok_t push_tok;
    bfr_pkg::tok_t pop_tok;
    bfr_pkg::res_t res;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address   <= bfr_pkg::RST_OWN_ADDR;
            cfg_reg.bit_threshold <= bfr_pkg::RST_BIT_THR;
            cfg_reg.start_min     <= bfr_pkg::RST_START_MIN;
            cfg_reg.start_max     <= bfr_pkg::RST_START_MAX;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bfr_pkg::CFG_OWN_ADDR:  cfg_reg.own_address <= cfg_wdata;
                bfr_pkg::CFG_BIT_THR:
                    cfg_reg.bit_threshold <= cfg_wdata[bfr_pkg::TICK_W-1:0];
                bfr_pkg::CFG_START_MIN:
                    cfg_reg.start_min <= cfg_wdata[bfr_pkg::TICK_W-1:0];
                bfr_pkg::CFG_START_MAX:
                    cfg_reg.start_max <= cfg_wdata[bfr_pkg::TICK_W-1:0];
            endcase
        end
    end

    bfr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_tok    (push_tok)
    );

    bfr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_tok (push_tok),
        .pop      (q_pop),
        .pop_tok  (pop_tok),
        .full     (q_full),
        .empty    (q_empty)
    );

    bfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_tok    (pop_tok),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res      (res)
    );

    assign m_tuser = res.event_res;
    assign m_tlast = res.is_last;
    assign m_tdata = {{(bfr_pkg::M_DATA_W - bfr_pkg::RES_BITS){1'b0}},
                      res.drive_ack,
                      res.data_byte,
                      res.length,
                      res.addressed_to_me,
                      res.slave_address,
                      res.master_address,
                      res.is_broadcast,
                      res.error_code};

endmodule

// ===== hdl/bfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_checker: port-level checks of the bus frame receiver
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module bfr_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bfr_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic [1:0]                    m_tuser,
    input  logic                          m_tlast
);

    logic [2:0]                 err_code;
    logic [bfr_pkg::BYTE_W-1:0] data_byte;
    logic                       drive_ack;
    logic                       match;

    assign err_code  = m_tdata[bfr_pkg::OFS_ERR +: 3];
    assign data_byte = m_tdata[bfr_pkg::OFS_DATA +: bfr_pkg::BYTE_W];
    assign drive_ack = m_tdata[bfr_pkg::OFS_ACK];
    assign match     = m_tdata[bfr_pkg::OFS_MATCH];

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_err_code_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == bfr_pkg::EV_ERROR) == (err_code != bfr_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bfr_pkg::EV_ERROR |-> !m_tlast && !drive_ack
                                                     && data_byte == '0)
        else $error("error result carries data, last or ack");

    a_ack_req_ours: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bfr_pkg::EV_ACK_REQ |-> drive_ack && match && !m_tlast)
        else $error("ack request for a frame not addressed here");

endmodule

bind bus_frame_receiver_top bfr_checker u_bfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bus_frame_receiver_top
// Feeds measured bit-slot pulses through the stream input, mirrors the frame
// decoder in a local model and checks every result word field by field.
// A short table of directed pulses is followed by randomly built frames,
// noise and corrupted parity, run under several register settings while
// both stream sides stall at random in all but one of the settings.
// ----------------------------------------------------------------------------
module testbench;
    import bfr_pkg::*;

    // decoder position within a frame
    typedef enum logic [3:0] {
        RX_IDLE, RX_BCAST, RX_MADDR, RX_MPAR, RX_SADDR, RX_SPAR, RX_ACK1, RX_CTRL,
        RX_CPAR, RX_ACK2, RX_LEN, RX_LPAR, RX_ACK3, RX_DATA, RX_DPAR, RX_DACK
    } rx_phase_t;

    // directed pulse; a pinned error code gives a fixed start-error result
    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic [2:0]        pinned_err;
    } dir_row_t;

    // register setting; 8-bit registers get junk in the upper nibble
    typedef struct packed {
        logic [CFG_W-1:0] own;
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] smin;
        logic [CFG_W-1:0] smax;
        logic [CFG_W-1:0] items;
    } cfg_row_t;

    localparam int N_DIR  = 19;
    localparam int N_CFG  = 7;
    localparam int HOLD_CYCLES = 200;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TICK_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // register copies
    logic [ADDR_W-1:0] cfg_own  = 12'd0;
    logic [TICK_W-1:0] cfg_thr  = 8'd8;
    logic [TICK_W-1:0] cfg_smin = 8'd10;
    logic [TICK_W-1:0] cfg_smax = 8'd254;

    // decoder state
    rx_phase_t         rx_phase  = RX_IDLE;
    logic [CNT_W-1:0]  rx_cnt    = '0;
    logic [ADDR_W-1:0] rx_shift  = '0;
    logic              rx_par    = 1'b0;
    logic              rx_bcast  = 1'b0;
    logic [ADDR_W-1:0] rx_master = '0;
    logic [ADDR_W-1:0] rx_slave  = '0;
    logic              rx_match  = 1'b0;
    logic [BYTE_W-1:0] rx_len    = '0;
    logic [BYTE_W-1:0] rx_idx    = '0;

    res_t pending_results[$];
    int   error_count = 0;
    int   sent_items  = 0;
    bit   steady      = 1'b0;
    int   hold_reqs   = 0;
    int   hold_seen   = 0;
    int   hold_left   = 0;

    // start errors first, then a frame with a bad master parity bit
    dir_row_t dir_rows [N_DIR] = '{
        {8'd255, ERR_START_LONG}, {8'd9, ERR_START_SHORT}, {8'd0, ERR_START_SHORT},
        {8'd254, ERR_NONE}, {8'd7, ERR_NONE},
        {8'd0, ERR_NONE}, {8'd8, ERR_NONE}, {8'd255, ERR_NONE}, {8'd7, ERR_NONE},
        {8'd0, ERR_NONE}, {8'd0, ERR_NONE}, {8'd8, ERR_NONE}, {8'd200, ERR_NONE},
        {8'd1, ERR_NONE}, {8'd255, ERR_NONE}, {8'd3, ERR_NONE}, {8'd8, ERR_NONE},
        {8'd0, ERR_NONE}, {8'd10, ERR_NONE}
    };

    // last row is replaced by a random setting at run time
    cfg_row_t cfg_rows [N_CFG] = '{
        {12'hFFF, 12'h308, 12'hC0A, 12'h5FE, 12'd400},
        {12'h000, 12'h0FF, 12'h000, 12'hFFF, 12'd300},
        {12'h5A3, 12'h001, 12'h0FF, 12'h0FF, 12'd150},
        {12'h000, 12'hA00, 12'h000, 12'h000, 12'd100},
        {12'h123, 12'h080, 12'h064, 12'h032, 12'd60},
        {12'h9E1, 12'h040, 12'h020, 12'h0C8, 12'd440},
        {12'h000, 12'h000, 12'h000, 12'h000, 12'd400}
    };

    bus_frame_receiver_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    task automatic report(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic cmp_field(input string name, input logic [11:0] got,
                             input logic [11:0] want);
        if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ---------------------------------------------------------------- decoder
    function automatic void start_field(input rx_phase_t ph);
        rx_phase = ph;
        rx_cnt   = '0;
        rx_shift = '0;
        rx_par   = 1'b0;
    endfunction

    function automatic bit shift_in(input logic b, input logic [CNT_W-1:0] width);
        rx_shift = {rx_shift[ADDR_W-2:0], b};
        rx_par   = rx_par ^ b;
        rx_cnt   = rx_cnt + 4'd1;
        return rx_cnt >= width;
    endfunction

    function automatic res_t frame_result(input logic [1:0] ev, input logic [2:0] code,
                                          input logic [7:0] data, input logic last,
                                          input logic ack);
        res_t r;
        r.event_res       = ev;
        r.error_code      = code;
        r.is_broadcast    = rx_bcast;
        r.master_address  = rx_master;
        r.slave_address   = rx_slave;
        r.addressed_to_me = rx_match;
        r.length          = rx_len;
        r.data_byte       = data;
        r.is_last         = last;
        r.drive_ack       = ack;
        return r;
    endfunction

    // advance the decoder by one pulse; returns 1 when a result comes out
    function automatic bit decode_pulse(input logic [TICK_W-1:0] t, output res_t r);
        logic              b;
        logic [BYTE_W-1:0] next_idx;
        bit                has;
        b   = (t < cfg_thr);
        r   = '0;
        has = 1'b0;
        case (rx_phase)
            RX_IDLE: begin
                // too long wins over too short
                if (t > cfg_smax) begin
                    r.event_res = EV_ERROR; r.error_code = ERR_START_LONG; has = 1'b1;
                end else if (t < cfg_smin) begin
                    r.event_res = EV_ERROR; r.error_code = ERR_START_SHORT; has = 1'b1;
                end else begin
                    rx_phase = RX_BCAST;
                end
            end
            RX_BCAST: begin
                rx_bcast = b;
                start_field(RX_MADDR);
            end
            RX_MADDR: begin
                if (shift_in(b, ADDR_BITS)) begin
                    rx_master = rx_shift;
                    rx_phase  = RX_MPAR;
                end
            end
            RX_SADDR: begin
                if (shift_in(b, ADDR_BITS)) begin
                    rx_slave = rx_shift;
                    rx_match = (rx_shift == cfg_own);
                    rx_phase = RX_SPAR;
                end
            end
            RX_CTRL: begin
                if (shift_in(b, CTRL_BITS)) rx_phase = RX_CPAR;
            end
            RX_LEN: begin
                if (shift_in(b, BYTE_BITS)) begin
                    rx_len   = rx_shift[BYTE_W-1:0];
                    rx_phase = RX_LPAR;
                end
            end
            RX_DATA: begin
                if (shift_in(b, BYTE_BITS)) rx_phase = RX_DPAR;
            end
            RX_ACK1: start_field(RX_CTRL);
            RX_ACK2: start_field(RX_LEN);
            RX_ACK3: begin
                if (rx_len > MAX_LEN) begin
                    r = frame_result(EV_ERROR, ERR_LEN, 8'd0, 1'b0, 1'b0);
                    has = 1'b1;
                    rx_phase = RX_IDLE;
                end else begin
                    rx_idx = '0;
                    if (rx_len == 8'd0) rx_phase = RX_IDLE;
                    else start_field(RX_DATA);
                end
            end
            RX_DACK: begin
                rx_idx = rx_idx + 8'd1;
                if (rx_idx >= rx_len) rx_phase = RX_IDLE;
                else start_field(RX_DATA);
            end
            default: begin
                // parity slots: MPAR, SPAR, CPAR, LPAR, DPAR
                if (b != rx_par) begin
                    r = frame_result(EV_ERROR, ERR_PARITY, 8'd0, 1'b0, 1'b0);
                    has = 1'b1;
                    rx_phase = RX_IDLE;
                end else begin
                    case (rx_phase)
                        RX_MPAR: start_field(RX_SADDR);
                        RX_SPAR, RX_CPAR: begin
                            rx_phase = (rx_phase == RX_SPAR) ? RX_ACK1 : RX_ACK2;
                            if (rx_match) begin
                                r = frame_result(EV_ACK_REQ, ERR_NONE, 8'd0, 1'b0, 1'b1);
                                has = 1'b1;
                            end
                        end
                        RX_LPAR: begin
                            rx_phase = RX_ACK3;
                            if (rx_len <= MAX_LEN) begin
                                r = frame_result(EV_HEADER, ERR_NONE, 8'd0,
                                                 rx_len == 8'd0, rx_match);
                                has = 1'b1;
                            end else if (rx_match) begin
                                r = frame_result(EV_ACK_REQ, ERR_NONE, 8'd0, 1'b0, 1'b1);
                                has = 1'b1;
                            end
                        end
                        default: begin
                            rx_phase = RX_DACK;
                            next_idx = rx_idx + 8'd1;
                            r = frame_result(EV_DATA, ERR_NONE, rx_shift[BYTE_W-1:0],
                                             next_idx == rx_len, rx_match);
                            has = 1'b1;
                        end
                    endcase
                end
            end
        endcase
        return has;
    endfunction

    // ---------------------------------------------------------------- sender
    // s_tvalid is only lowered inside a gap, so a back-to-back transfer keeps it high
    task automatic send_pulse(input logic [TICK_W-1:0] t, input logic [2:0] pinned_err);
        res_t r;
        bit   has;
        if (!steady) begin
            while ($urandom_range(99, 0) < 30) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        has = decode_pulse(t, r);
        if (pinned_err != ERR_NONE) begin
            r = '0;
            r.event_res  = EV_ERROR;
            r.error_code = pinned_err;
            has = 1'b1;
        end
        if (has) pending_results.push_back(r);
        sent_items++;
    endtask

    task automatic send_bit(input logic b);
        logic [TICK_W-1:0] t;
        if (b && cfg_thr != 8'd0) begin
            if ($urandom_range(7, 0) == 0) t = cfg_thr - 8'd1;
            else t = 8'($urandom_range(cfg_thr - 1, 0));
        end else if (!b) begin
            if ($urandom_range(7, 0) == 0) t = cfg_thr;
            else t = 8'($urandom_range(255, cfg_thr));
        end else begin
            t = 8'd0;   // threshold zero: nothing decodes as one
        end
        send_pulse(t, ERR_NONE);
    endtask

    // MSB first, then even parity, now and then flipped
    task automatic send_field(input logic [11:0] value, input logic [CNT_W-1:0] width);
        logic par;
        int   i;
        par = 1'b0;
        for (i = int'(width) - 1; i >= 0; i--) begin
            send_bit(value[i]);
            par = par ^ value[i];
        end
        send_bit(par ^ ($urandom_range(39, 0) == 0));
    endtask

    task automatic send_frame();
        logic [TICK_W-1:0] t;
        logic [ADDR_W-1:0] slave;
        logic [BYTE_W-1:0] len;
        int                pick;
        if (cfg_smin <= cfg_smax) begin
            pick = $urandom_range(5, 0);
            if (pick == 0) t = cfg_smin;
            else if (pick == 1) t = cfg_smax;
            else t = 8'($urandom_range(cfg_smax, cfg_smin));
        end else begin
            t = 8'($urandom_range(255, 0));
        end
        send_pulse(t, ERR_NONE);
        if (rx_phase == RX_IDLE) return;
        send_bit(1'($urandom_range(1, 0)));
        send_field(12'($urandom_range(4095, 0)), ADDR_BITS);
        if (rx_phase == RX_IDLE) return;
        slave = $urandom_range(1, 0) ? cfg_own : 12'($urandom_range(4095, 0));
        send_field(slave, ADDR_BITS);
        if (rx_phase == RX_IDLE) return;
        send_pulse(8'($urandom_range(255, 0)), ERR_NONE);
        send_field(12'($urandom_range(15, 0)), CTRL_BITS);
        if (rx_phase == RX_IDLE) return;
        send_pulse(8'($urandom_range(255, 0)), ERR_NONE);
        pick = $urandom_range(99, 0);
        if (pick < 15) len = 8'd0;
        else if (pick < 60) len = 8'($urandom_range(4, 1));
        else if (pick < 80) len = 8'($urandom_range(MAX_LEN, 5));
        else if (pick < 90) len = MAX_LEN + 8'($urandom_range(1, 0));
        else len = 8'($urandom_range(255, MAX_LEN + 1));
        send_field({4'd0, len}, BYTE_BITS);
        if (rx_phase == RX_IDLE) return;
        // ack slot after length: ends the frame if empty or oversized
        send_pulse(8'($urandom_range(255, 0)), ERR_NONE);
        while (rx_phase != RX_IDLE) begin
            send_field(12'($urandom_range(255, 0)), BYTE_BITS);
            if (rx_phase == RX_IDLE) return;
            send_pulse(8'($urandom_range(255, 0)), ERR_NONE);
        end
    endtask

    // 255 always decodes as zero, so a frame of zero bits runs out cleanly
    task automatic flush_frame();
        while (rx_phase != RX_IDLE) send_pulse(8'd255, ERR_NONE);
    endtask

    // stop sending, wait for every expected result, then let the queue go quiet
    task automatic settle();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() > 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() > 0) begin
            report($sformatf("%0d results never came", pending_results.size()));
            pending_results.delete();
        end
        repeat (FIFO_DEPTH + 6) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_OWN_ADDR:  cfg_own  = val;
            CFG_BIT_THR:   cfg_thr  = val[TICK_W-1:0];
            CFG_START_MIN: cfg_smin = val[TICK_W-1:0];
            default:       cfg_smax = val[TICK_W-1:0];
        endcase
    endtask

    task automatic program_regs(input cfg_row_t c);
        put_reg(CFG_OWN_ADDR, c.own);
        put_reg(CFG_BIT_THR, c.thr);
        put_reg(CFG_START_MIN, c.smin);
        put_reg(CFG_START_MAX, c.smax);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- receiver
    always @(posedge aclk) begin : rx_ready
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= 30);
        end
    end

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result, event %0d", m_tuser));
            end else begin
                want = pending_results.pop_front();
                cmp_field("event_res", m_tuser, want.event_res);
                cmp_field("error_code", m_tdata[OFS_ERR +: 3], want.error_code);
                cmp_field("is_broadcast", m_tdata[OFS_BCAST], want.is_broadcast);
                cmp_field("master_address", m_tdata[OFS_MASTER +: ADDR_W],
                          want.master_address);
                cmp_field("slave_address", m_tdata[OFS_SLAVE +: ADDR_W],
                          want.slave_address);
                cmp_field("addressed_to_me", m_tdata[OFS_MATCH], want.addressed_to_me);
                cmp_field("length", m_tdata[OFS_LEN +: BYTE_W], want.length);
                cmp_field("data_byte", m_tdata[OFS_DATA +: BYTE_W], want.data_byte);
                cmp_field("is_last", m_tlast, want.is_last);
                cmp_field("drive_ack", m_tdata[OFS_ACK], want.drive_ack);
            end
        end
    end

    // ---------------------------------------------------------------- main
    initial begin
        int       row;
        int       set;
        int       phase_start;
        bit       held;
        cfg_row_t c;
        logic [TICK_W-1:0] lo;
        logic [TICK_W-1:0] hi;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults straight after reset
        for (row = 0; row < N_DIR; row++)
            send_pulse(dir_rows[row].ticks, dir_rows[row].pinned_err);
        flush_frame();
        settle();

        for (set = 0; set < N_CFG; set++) begin
            c = cfg_rows[set];
            if (set == N_CFG - 1) begin
                lo = 8'($urandom_range(255, 0));
                hi = 8'($urandom_range(255, 0));
                if (lo > hi) begin
                    lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
                end
                c.own  = 12'($urandom_range(4095, 0));
                c.thr  = {4'($urandom_range(15, 0)), 8'($urandom_range(255, 2))};
                c.smin = {4'($urandom_range(15, 0)), lo};
                c.smax = {4'($urandom_range(15, 0)), hi};
            end
            program_regs(c);
            steady = (set == 1);
            phase_start = sent_items;
            held = 1'b0;
            while (sent_items - phase_start < int'(c.items)) begin
                // one long output stall while input keeps coming
                if (set == 0 && !held && sent_items - phase_start > 120) begin
                    hold_reqs++;
                    held = 1'b1;
                end
                if ($urandom_range(99, 0) < 12) begin
                    repeat ($urandom_range(5, 1))
                        send_pulse(8'($urandom_range(255, 0)), ERR_NONE);
                end else begin
                    send_frame();
                end
            end
            flush_frame();
            settle();
        end
        steady = 1'b0;
        repeat (20) @(posedge aclk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bfr_pkg.sv
hdl/bfr_front.sv
hdl/bfr_fifo.sv
hdl/bfr_back.sv
hdl/bus_frame_receiver_top.sv
hdl/bfr_checker.sv
bench/testbench.sv
